// ===== rtl/clt_pkg.sv =====
package clt_pkg;

    // Characters that the splitting rules look at.
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // One character can cause at most this many result words.
    localparam int RES_SLOTS = 3;
    localparam int SLOT_BITS = 2;

    // Tokenizer phase.
    typedef enum logic [2:0] {
        PH_START        = 3'd0,
        PH_FIRST_PLAIN  = 3'd1,
        PH_FIRST_QUOTED = 3'd2,
        PH_SKIP         = 3'd3,
        PH_ARG          = 3'd4
    } t_phase;

    // Kind of a result word.
    typedef enum logic [1:0] {
        K_RUN     = 2'd0,
        K_ARGEND  = 2'd1,
        K_LINEEND = 2'd2
    } t_kind;

    // One result word without its last flag.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_char;
        logic [7:0]  repeat_res;
        logic [15:0] arg_total;
    } t_result;

    // All result words caused by one character.
    typedef struct packed {
        t_result [RES_SLOTS-1:0] item;
        logic [SLOT_BITS-1:0]    count;
    } t_group;

endpackage

// ===== rtl/clt_in_if.sv =====
interface clt_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       end_of_line;

    modport source (output valid, output ch, output end_of_line, input ready);
    modport sink (input valid, input ch, input end_of_line, output ready);
endinterface

// ===== rtl/clt_out_if.sv =====
interface clt_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  out_char;
    logic [7:0]  repeat_res;
    logic [15:0] arg_total;
    logic        last;

    modport source (output valid, output kind, output out_char, output repeat_res,
                    output arg_total, output last, input ready);
    modport sink (input valid, input kind, input out_char, input repeat_res,
                  input arg_total, input last, output ready);
endinterface

// ===== rtl/command_line_tokenizer.sv =====
// Splits a command line into arguments, taking one character word per cycle on i_in
// while the input is ready, and gives out result words on o_out: runs of one
// character, argument ends and a final line end carrying the argument count. Plain
// text streams at one character per cycle while o_out takes each word; a character
// that causes several words (at most three, as at the line end) holds the input
// until the three-entry result register, which drains one word per cycle while
// o_out is ready, hands out its last one; a character that causes no word (a backslash,
// an opening quote, a blank between arguments) does not hold it. The input is ready
// whenever the result register is empty or its last word is taken in that cycle.
// Backslash runs and the argument count saturate at RUN_COUNT_BITS and
// ARG_COUNT_BITS; repeat_res and arg_total show the low 8 and 16 bits of them.
module command_line_tokenizer #(
    parameter int RUN_COUNT_BITS = 8,
    parameter int ARG_COUNT_BITS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    clt_in_if.sink    i_in,
    clt_out_if.source o_out
);

    logic             accept;
    logic             room;
    clt_pkg::t_group  grp;
    clt_pkg::t_result head;

    // Input handshake.
    assign i_in.ready = room;
    assign accept     = i_in.valid && room;

    // Tokenizer state and per-character decode.
    clt_step #(
        .RUN_COUNT_BITS (RUN_COUNT_BITS),
        .ARG_COUNT_BITS (ARG_COUNT_BITS)
    ) u_step (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_ch     (i_in.ch),
        .i_eol    (i_in.end_of_line),
        .o_grp    (grp)
    );

    // Result register that hands out one word per cycle while o_out is ready.
    clt_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_grp   (grp),
        .i_take  (o_out.ready),
        .o_valid (o_out.valid),
        .o_head  (head),
        .o_last  (o_out.last),
        .o_room  (room)
    );

    // Output word fields.
    assign o_out.kind       = head.kind;
    assign o_out.out_char   = head.out_char;
    assign o_out.repeat_res = head.repeat_res;
    assign o_out.arg_total  = head.arg_total;

endmodule

// ===== rtl/clt_step.sv =====
module clt_step #(
    parameter int RUN_COUNT_BITS = 8,
    parameter int ARG_COUNT_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_accept,
    input  logic [7:0]      i_ch,
    input  logic            i_eol,
    output clt_pkg::t_group o_grp
);

    localparam logic [RUN_COUNT_BITS-1:0] RUN_MAX = '1;
    localparam logic [ARG_COUNT_BITS-1:0] ARG_MAX = '1;

    clt_pkg::t_phase             r_phase, n_phase;
    logic [RUN_COUNT_BITS-1:0]   r_pend, n_pend;
    logic [1:0]                  r_qc, n_qc;
    logic                        r_iq, n_iq;
    logic [ARG_COUNT_BITS-1:0]   r_argc, n_argc;

    function automatic clt_pkg::t_result mk_res(clt_pkg::t_kind kind, logic [7:0] c,
                                                logic [7:0] rep, logic [15:0] total);
        clt_pkg::t_result r;
        r.kind       = kind;
        r.out_char   = c;
        r.repeat_res = rep;
        r.arg_total  = total;
        return r;
    endfunction

    // Next state and the result words of the current character.
    always_comb begin
        logic [RUN_COUNT_BITS-1:0] pb;
        logic [1:0]                qc;
        logic                      iq;
        clt_pkg::t_phase           ph;
        logic [ARG_COUNT_BITS-1:0] ac;
        logic [1:0]                k;
        logic                      blank;
        logic                      do_arg;
        logic [RUN_COUNT_BITS-1:0] half;

        pb     = r_pend;
        qc     = r_qc;
        iq     = r_iq;
        ph     = r_phase;
        ac     = r_argc;
        k      = '0;
        o_grp  = '0;
        do_arg = 1'b0;
        half   = r_pend >> 1;
        blank  = (i_ch == clt_pkg::CH_SPACE) || (i_ch == clt_pkg::CH_TAB);

        if (i_eol) begin
            // Flush the open argument, then report the count.
            if (ph == clt_pkg::PH_ARG) begin
                if (pb != '0) begin
                    o_grp.item[k] = mk_res(clt_pkg::K_RUN, clt_pkg::CH_BSLASH, 8'(pb), '0);
                    k = k + 2'd1;
                end
                o_grp.item[k] = mk_res(clt_pkg::K_ARGEND, '0, '0, '0);
                k = k + 2'd1;
            end else if (ph == clt_pkg::PH_FIRST_PLAIN || ph == clt_pkg::PH_FIRST_QUOTED) begin
                o_grp.item[k] = mk_res(clt_pkg::K_ARGEND, '0, '0, '0);
                k = k + 2'd1;
            end
            o_grp.item[k] = mk_res(clt_pkg::K_LINEEND, '0, '0, 16'(ac));
            k  = k + 2'd1;
            ph = clt_pkg::PH_START;
            pb = '0;
            qc = '0;
            iq = 1'b0;
            ac = '0;
        end else begin
            case (ph)
                clt_pkg::PH_FIRST_PLAIN: begin
                    if (blank) begin
                        o_grp.item[k] = mk_res(clt_pkg::K_ARGEND, '0, '0, '0);
                        k  = k + 2'd1;
                        ph = clt_pkg::PH_SKIP;
                    end else begin
                        o_grp.item[k] = mk_res(clt_pkg::K_RUN, i_ch, 8'd1, '0);
                        k = k + 2'd1;
                    end
                end
                clt_pkg::PH_FIRST_QUOTED: begin
                    if (i_ch == clt_pkg::CH_QUOTE) begin
                        o_grp.item[k] = mk_res(clt_pkg::K_ARGEND, '0, '0, '0);
                        k  = k + 2'd1;
                        ph = clt_pkg::PH_SKIP;
                    end else begin
                        o_grp.item[k] = mk_res(clt_pkg::K_RUN, i_ch, 8'd1, '0);
                        k = k + 2'd1;
                    end
                end
                clt_pkg::PH_SKIP: begin
                    // A non-blank character opens the next argument.
                    if (!blank) begin
                        if (ac != ARG_MAX) begin
                            ac = ac + 1'b1;
                        end
                        ph     = clt_pkg::PH_ARG;
                        pb     = '0;
                        qc     = '0;
                        iq     = 1'b0;
                        half   = '0;
                        do_arg = 1'b1;
                    end
                end
                clt_pkg::PH_ARG: begin
                    do_arg = 1'b1;
                end
                default: begin
                    // Start of line; codes that mean nothing act the same.
                    ac = ARG_COUNT_BITS'(1);
                    if (i_ch == clt_pkg::CH_QUOTE) begin
                        ph = clt_pkg::PH_FIRST_QUOTED;
                    end else if (blank) begin
                        o_grp.item[k] = mk_res(clt_pkg::K_ARGEND, '0, '0, '0);
                        k  = k + 2'd1;
                        ph = clt_pkg::PH_SKIP;
                    end else begin
                        o_grp.item[k] = mk_res(clt_pkg::K_RUN, i_ch, 8'd1, '0);
                        k  = k + 2'd1;
                        ph = clt_pkg::PH_FIRST_PLAIN;
                    end
                end
            endcase

            // Rules inside a later argument.
            if (do_arg) begin
                if (iq && i_ch == clt_pkg::CH_QUOTE) begin
                    // Another quote of a run: every third one is literal.
                    qc = qc + 2'd1;
                    if (qc == 2'd3) begin
                        o_grp.item[k] = mk_res(clt_pkg::K_RUN, clt_pkg::CH_QUOTE, 8'd1, '0);
                        k  = k + 2'd1;
                        qc = '0;
                    end
                end else begin
                    if (iq) begin
                        iq = 1'b0;
                        if (qc == 2'd2) begin
                            qc = '0;
                        end
                    end
                    if (blank && qc == 2'd0) begin
                        if (pb != '0) begin
                            o_grp.item[k] = mk_res(clt_pkg::K_RUN, clt_pkg::CH_BSLASH,
                                                   8'(pb), '0);
                            k = k + 2'd1;
                        end
                        pb = '0;
                        o_grp.item[k] = mk_res(clt_pkg::K_ARGEND, '0, '0, '0);
                        k  = k + 2'd1;
                        ph = clt_pkg::PH_SKIP;
                    end else if (i_ch == clt_pkg::CH_BSLASH) begin
                        if (pb != RUN_MAX) begin
                            pb = pb + 1'b1;
                        end
                    end else if (i_ch == clt_pkg::CH_QUOTE) begin
                        // Backslashes before a quote are halved.
                        if (half != '0) begin
                            o_grp.item[k] = mk_res(clt_pkg::K_RUN, clt_pkg::CH_BSLASH,
                                                   8'(half), '0);
                            k = k + 2'd1;
                        end
                        if (pb[0] == 1'b0) begin
                            qc = qc + 2'd1;
                        end else begin
                            o_grp.item[k] = mk_res(clt_pkg::K_RUN, clt_pkg::CH_QUOTE,
                                                   8'd1, '0);
                            k = k + 2'd1;
                        end
                        pb = '0;
                        iq = 1'b1;
                    end else begin
                        if (pb != '0) begin
                            o_grp.item[k] = mk_res(clt_pkg::K_RUN, clt_pkg::CH_BSLASH,
                                                   8'(pb), '0);
                            k = k + 2'd1;
                        end
                        pb = '0;
                        o_grp.item[k] = mk_res(clt_pkg::K_RUN, i_ch, 8'd1, '0);
                        k = k + 2'd1;
                    end
                end
            end
        end

        o_grp.count = k;
        n_phase     = ph;
        n_pend      = pb;
        n_qc        = qc;
        n_iq        = iq;
        n_argc      = ac;
    end

    // Tokenizer state advances on each accepted word.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= clt_pkg::PH_START;
            r_pend  <= '0;
            r_qc    <= '0;
            r_iq    <= 1'b0;
            r_argc  <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_pend  <= n_pend;
            r_qc    <= n_qc;
            r_iq    <= n_iq;
            r_argc  <= n_argc;
        end
    end

    // Backslashes are only held inside a later argument.
    a_pend_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == clt_pkg::PH_START || r_phase == clt_pkg::PH_SKIP) |-> r_pend == '0)
        else $error("backslashes held outside an argument");

    // Nothing has been counted at the start of a line.
    a_argc_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == clt_pkg::PH_START |-> r_argc == '0)
        else $error("argument count not cleared at start of line");

endmodule

// ===== rtl/clt_result_queue.sv =====
module clt_result_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  clt_pkg::t_group  i_grp,
    input  logic             i_take,
    output logic             o_valid,
    output clt_pkg::t_result o_head,
    output logic             o_last,
    output logic             o_room
);

    clt_pkg::t_result [clt_pkg::RES_SLOTS-1:0] r_item;
    logic [clt_pkg::SLOT_BITS-1:0]             r_cnt;

    // Head of the queue drives the output word.
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_item[0];
    assign o_last  = (r_cnt == clt_pkg::SLOT_BITS'(1));
    assign o_room  = (r_cnt == '0) || (o_last && i_take);

    // Control: word count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_load) begin
            r_cnt <= i_grp.count;
        end else if (o_valid && i_take) begin
            r_cnt <= r_cnt - 1'b1;
        end
    end

    // Payload: load a whole group or shift toward the head.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= i_grp.item;
        end else if (o_valid && i_take) begin
            for (int i = 0; i < clt_pkg::RES_SLOTS - 1; i++) begin
                r_item[i] <= r_item[i+1];
            end
        end
    end

    // A new group never overwrites words still waiting.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == '0 || (r_cnt == clt_pkg::SLOT_BITS'(1) && i_take)))
        else $error("group loaded over pending words");

    // A stalled queue keeps its count.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_take && !i_load) |=> $stable(r_cnt))
        else $error("word count changed while stalled");

    // The line end is always the final word of its group.
    a_lineend_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_head.kind == clt_pkg::K_LINEEND) |-> o_last)
        else $error("line end word is not last");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;

    localparam int RUN_BITS   = 8;
    localparam int ARG_BITS   = 16;
    localparam int unsigned RUN_MAX = 2**RUN_BITS - 1;
    localparam int unsigned ARG_MAX = 2**ARG_BITS - 1;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 20;

    // One character word waiting to be sent, with the idle gap that follows it.
    typedef struct {
        logic [7:0]  ch;
        logic        eol;
        int unsigned gap;
    } t_char_word;

    // One expected result word.
    typedef struct {
        clt_pkg::t_kind kind;
        logic [7:0]     out_char;
        logic [7:0]     repeat_res;
        logic [15:0]    arg_total;
        logic           last;
    } t_tok_word;

    logic i_clk;
    logic i_rst_n;

    clt_in_if  in_if ();
    clt_out_if out_if ();

    command_line_tokenizer #(
        .RUN_COUNT_BITS(RUN_BITS),
        .ARG_COUNT_BITS(ARG_BITS)
    ) i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_if),
        .o_out  (out_if)
    );

    t_char_word  pending_chars[$];
    t_tok_word   expected_words[$];
    t_tok_word   step_words[$];

    // Tokenizer state as predicted from the accepted characters.
    clt_pkg::t_phase tok_phase;
    int unsigned     tok_backslashes;
    int unsigned     tok_quotes;
    bit              tok_in_quote_run;
    int unsigned     tok_args;

    int unsigned errors;
    int unsigned lines_sent;
    int unsigned chars_taken;
    int unsigned words_checked;
    int unsigned longest_bs_run;
    int unsigned most_args;
    int unsigned gap_left;
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned quiet_left;
    int unsigned idle_cycles;
    t_char_word  next_char;
    t_tok_word   want;

    // Clock.
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Idle length: mostly short, now and then long.
    function automatic int unsigned gap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] pick_blank();
        return $urandom_range(0, 1) ? clt_pkg::CH_SPACE : clt_pkg::CH_TAB;
    endfunction

    // A byte with no special meaning to the splitting rules.
    function automatic logic [7:0] pick_plain();
        logic [7:0] c;
        c = 8'($urandom_range(0, 255));
        if (c == clt_pkg::CH_QUOTE || c == clt_pkg::CH_BSLASH ||
            c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB)
            c = 8'h41 + 8'($urandom_range(0, 25));
        return c;
    endfunction

    // ---------------------------------------------------------------------
    // Stimulus building.
    // ---------------------------------------------------------------------
    task automatic push_word(logic [7:0] c, logic eol);
        t_char_word w;
        int unsigned r;
        w.ch  = c;
        w.eol = eol;
        r = $urandom_range(0, 99);
        if (quiet_left != 0) begin
            quiet_left--;
            w.gap = 0;
        end else if (r < 4) begin
            quiet_left = $urandom_range(10, 40);
            w.gap = 0;
        end else if (r < 50) begin
            w.gap = 0;
        end else begin
            w.gap = gap_len();
        end
        pending_chars.push_back(w);
    endtask

    task automatic push_char(logic [7:0] c);
        push_word(c, 1'b0);
    endtask

    // The character under an end-of-line word is random, since it is ignored.
    task automatic push_eol();
        push_word(8'($urandom_range(0, 255)), 1'b1);
        lines_sent++;
    endtask

    // One piece of a later argument.
    task automatic push_token();
        int unsigned r;
        r = $urandom_range(0, 5);
        case (r)
            0, 1: begin
                push_char(pick_plain());
            end
            2: begin
                repeat ($urandom_range(1, 5)) push_char(clt_pkg::CH_BSLASH);
                if ($urandom_range(0, 1)) push_char(clt_pkg::CH_QUOTE);
            end
            3: begin
                repeat ($urandom_range(1, 4)) push_char(clt_pkg::CH_QUOTE);
            end
            4: begin
                push_char(clt_pkg::CH_QUOTE);
                push_char(pick_blank());
                push_char(clt_pkg::CH_QUOTE);
            end
            default: begin
                push_char(8'($urandom_range(0, 255)));
            end
        endcase
    endtask

    // A well-formed line: a path, some arguments, an end-of-line word.
    task automatic push_line();
        int unsigned n_args;
        bit glued;
        logic [7:0] c;
        glued = 1'b0;
        if ($urandom_range(0, 4) == 0) push_char(pick_blank());
        if ($urandom_range(0, 1)) begin
            push_char(clt_pkg::CH_QUOTE);
            repeat ($urandom_range(0, 4)) begin
                c = 8'($urandom_range(0, 255));
                push_char(c == clt_pkg::CH_QUOTE ? clt_pkg::CH_BSLASH : c);
            end
            // An unclosed quoted path runs to the end of the line.
            if ($urandom_range(0, 4) == 0) begin
                push_eol();
                return;
            end
            push_char(clt_pkg::CH_QUOTE);
            glued = ($urandom_range(0, 2) == 0);
        end else begin
            repeat ($urandom_range(1, 4)) begin
                c = 8'($urandom_range(0, 255));
                push_char((c == clt_pkg::CH_SPACE || c == clt_pkg::CH_TAB) ? pick_plain() : c);
            end
        end
        n_args = $urandom_range(0, 4);
        for (int k = 0; k < n_args; k++) begin
            if (!(k == 0 && glued)) repeat ($urandom_range(1, 2)) push_char(pick_blank());
            repeat ($urandom_range(1, 4)) push_token();
        end
        if ($urandom_range(0, 3) == 0) push_char(pick_blank());
        push_eol();
    endtask

    // Random bytes with no structure, closed by an end-of-line word.
    task automatic push_noise_line();
        repeat ($urandom_range(1, 12)) push_char(8'($urandom_range(0, 255)));
        push_eol();
    endtask

    // ---------------------------------------------------------------------
    // Predictor of the tokenizer.
    // ---------------------------------------------------------------------
    task automatic emit(clt_pkg::t_kind k, logic [7:0] c, int unsigned rep,
                        int unsigned total);
        t_tok_word w;
        w.kind       = k;
        w.out_char   = c;
        w.repeat_res = rep[7:0];
        w.arg_total  = total[15:0];
        w.last       = 1'b0;
        step_words.push_back(w);
    endtask

    task automatic emit_backslashes(int unsigned count);
        if (count != 0) emit(clt_pkg::K_RUN, clt_pkg::CH_BSLASH, count, 0);
    endtask

    task automatic tokenizer_clear();
        tok_phase        = clt_pkg::PH_START;
        tok_backslashes  = 0;
        tok_quotes       = 0;
        tok_in_quote_run = 1'b0;
        tok_args         = 0;
    endtask

    // One character inside a later argument.
    task automatic tokenize_arg_char(logic [7:0] c);
        bit blank;
        blank = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
        // Consecutive quotes: every third one is a literal quote.
        if (tok_in_quote_run && c == clt_pkg::CH_QUOTE) begin
            tok_quotes++;
            if (tok_quotes >= 3) begin
                emit(clt_pkg::K_RUN, clt_pkg::CH_QUOTE, 1, 0);
                tok_quotes = 0;
            end
            return;
        end
        if (tok_in_quote_run) begin
            tok_in_quote_run = 1'b0;
            if (tok_quotes == 2) tok_quotes = 0;
        end
        if (blank && tok_quotes == 0) begin
            emit_backslashes(tok_backslashes);
            tok_backslashes = 0;
            emit(clt_pkg::K_ARGEND, 8'h00, 0, 0);
            tok_phase = clt_pkg::PH_SKIP;
        end else if (c == clt_pkg::CH_BSLASH) begin
            if (tok_backslashes < RUN_MAX) tok_backslashes++;
        end else if (c == clt_pkg::CH_QUOTE) begin
            // Backslashes before a quote are halved; an odd one escapes it.
            emit_backslashes(tok_backslashes >> 1);
            if (tok_backslashes[0] == 1'b0)
                tok_quotes = (tok_quotes + 1) & 3;
            else
                emit(clt_pkg::K_RUN, clt_pkg::CH_QUOTE, 1, 0);
            tok_backslashes  = 0;
            tok_in_quote_run = 1'b1;
        end else begin
            emit_backslashes(tok_backslashes);
            tok_backslashes = 0;
            emit(clt_pkg::K_RUN, c, 1, 0);
        end
    endtask

    // Expected result words for one accepted character word.
    task automatic tokenize_step(logic [7:0] c, logic eol);
        bit blank;
        t_tok_word w;
        blank = (c == clt_pkg::CH_SPACE) || (c == clt_pkg::CH_TAB);
        step_words.delete();
        if (eol) begin
            if (tok_phase == clt_pkg::PH_ARG) begin
                emit_backslashes(tok_backslashes);
                emit(clt_pkg::K_ARGEND, 8'h00, 0, 0);
            end else if (tok_phase == clt_pkg::PH_FIRST_PLAIN ||
                         tok_phase == clt_pkg::PH_FIRST_QUOTED) begin
                emit(clt_pkg::K_ARGEND, 8'h00, 0, 0);
            end
            emit(clt_pkg::K_LINEEND, 8'h00, 0, tok_args);
            tokenizer_clear();
        end else begin
            case (tok_phase)
                clt_pkg::PH_START: begin
                    tok_args = 1;
                    if (c == clt_pkg::CH_QUOTE) begin
                        tok_phase = clt_pkg::PH_FIRST_QUOTED;
                    end else if (blank) begin
                        emit(clt_pkg::K_ARGEND, 8'h00, 0, 0);
                        tok_phase = clt_pkg::PH_SKIP;
                    end else begin
                        emit(clt_pkg::K_RUN, c, 1, 0);
                        tok_phase = clt_pkg::PH_FIRST_PLAIN;
                    end
                end
                clt_pkg::PH_FIRST_PLAIN: begin
                    if (blank) begin
                        emit(clt_pkg::K_ARGEND, 8'h00, 0, 0);
                        tok_phase = clt_pkg::PH_SKIP;
                    end else begin
                        emit(clt_pkg::K_RUN, c, 1, 0);
                    end
                end
                clt_pkg::PH_FIRST_QUOTED: begin
                    if (c == clt_pkg::CH_QUOTE) begin
                        emit(clt_pkg::K_ARGEND, 8'h00, 0, 0);
                        tok_phase = clt_pkg::PH_SKIP;
                    end else begin
                        emit(clt_pkg::K_RUN, c, 1, 0);
                    end
                end
                clt_pkg::PH_SKIP: begin
                    if (!blank) begin
                        if (tok_args < ARG_MAX) tok_args++;
                        tok_phase        = clt_pkg::PH_ARG;
                        tok_backslashes  = 0;
                        tok_quotes       = 0;
                        tok_in_quote_run = 1'b0;
                        tokenize_arg_char(c);
                    end
                end
                default: begin
                    tokenize_arg_char(c);
                end
            endcase
        end
        foreach (step_words[i]) begin
            w = step_words[i];
            w.last = (i == step_words.size() - 1);
            expected_words.push_back(w);
        end
    endtask

    task automatic check_field(string name, logic [15:0] expv, logic [15:0] got);
        if (got !== expv) begin
            $error("%s mismatch: expected %0h, got %0h", name, expv, got);
            errors++;
        end
    endtask

    // ---------------------------------------------------------------------
    // Driver: sends the pending character words with random gaps.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_if.valid       <= 1'b0;
            in_if.ch          <= 8'h00;
            in_if.end_of_line <= 1'b0;
            gap_left = 0;
        end else begin
            if (in_if.valid && in_if.ready) begin
                tokenize_step(in_if.ch, in_if.end_of_line);
                chars_taken++;
            end
            if (!in_if.valid || in_if.ready) begin
                if (gap_left != 0) begin
                    gap_left--;
                    in_if.valid <= 1'b0;
                end else if (pending_chars.size() != 0) begin
                    next_char = pending_chars.pop_front();
                    in_if.valid       <= 1'b1;
                    in_if.ch          <= next_char.ch;
                    in_if.end_of_line <= next_char.eol;
                    gap_left = next_char.gap;
                end else begin
                    in_if.valid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Monitor: stalls the result side at random and checks each word.
    // ---------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_if.ready <= 1'b0;
        end else begin
            if (out_if.valid && out_if.ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected: kind %0d char %0h",
                           out_if.kind, out_if.out_char);
                    errors++;
                end else begin
                    want = expected_words.pop_front();
                    check_field("kind", 16'(want.kind), 16'(out_if.kind));
                    check_field("out_char", 16'(want.out_char), 16'(out_if.out_char));
                    check_field("repeat_res", 16'(want.repeat_res), 16'(out_if.repeat_res));
                    check_field("arg_total", want.arg_total, out_if.arg_total);
                    check_field("last", 16'(want.last), 16'(out_if.last));
                    words_checked++;
                end
                if (out_if.kind == clt_pkg::K_RUN && out_if.out_char == clt_pkg::CH_BSLASH &&
                    out_if.repeat_res > longest_bs_run)
                    longest_bs_run = out_if.repeat_res;
                if (out_if.kind == clt_pkg::K_LINEEND && out_if.arg_total > most_args)
                    most_args = out_if.arg_total;
            end
            if (stall_left != 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
                if (calm_left != 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 99) < 3) begin
                    calm_left = $urandom_range(30, 120);
                end else if ($urandom_range(0, 99) < 15) begin
                    stall_left = gap_len();
                end
            end
        end
    end

    // Watchdog: ends the run when neither side moves a word for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus and end of run.
    // ---------------------------------------------------------------------
    initial begin
        int unsigned start_size;
        i_rst_n = 1'b0;
        errors = 0;
        lines_sent = 0;
        chars_taken = 0;
        words_checked = 0;
        longest_bs_run = 0;
        most_args = 0;
        stall_left = 0;
        calm_left = 0;
        quiet_left = 0;
        idle_cycles = 0;
        tokenizer_clear();

        // Empty line.
        push_eol();
        // A leading tab ends an empty path at once.
        push_char(clt_pkg::CH_TAB);
        push_char("a");
        push_eol();
        // Unquoted path of a zero byte, then a trailing blank.
        push_char(8'h00);
        push_char(clt_pkg::CH_SPACE);
        push_eol();
        // Quoted path holding a blank; the closing quote glues on the next argument.
        push_char(clt_pkg::CH_QUOTE);
        push_char(8'hFF);
        push_char(clt_pkg::CH_SPACE);
        push_char(clt_pkg::CH_QUOTE);
        push_char("b");
        // Three backslashes and a quote: one backslash and a literal quote.
        repeat (3) push_char(clt_pkg::CH_BSLASH);
        push_char(clt_pkg::CH_QUOTE);
        // Three more quotes in the same run give one literal quote.
        repeat (3) push_char(clt_pkg::CH_QUOTE);
        // Two backslashes and a quote: one backslash, quoting opens.
        repeat (2) push_char(clt_pkg::CH_BSLASH);
        push_char(clt_pkg::CH_QUOTE);
        // Quoted space, then two quotes cancel and a tab ends the argument.
        push_char(clt_pkg::CH_SPACE);
        push_char(clt_pkg::CH_QUOTE);
        push_char(clt_pkg::CH_TAB);
        // Backslashes still pending at the line end come out as a run.
        repeat (2) push_char(clt_pkg::CH_BSLASH);
        push_eol();

        // Random lines, mostly well formed.
        start_size = pending_chars.size();
        while (pending_chars.size() - start_size < 90) begin
            if ($urandom_range(0, 4) == 0)
                push_noise_line();
            else
                push_line();
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_chars.size() != 0 || in_if.valid) @(posedge i_clk);
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Sent %0d lines as %0d character words; checked %0d result words.",
                 lines_sent, chars_taken, words_checked);
        $display("Longest backslash run seen %0d, largest argument count seen %0d.",
                 longest_bs_run, most_args);
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
